// ===== sv/aff_pkg.sv =====
// shared types, command codes and fixed-point constants of the affine transform engine
package aff_pkg;

  localparam int REQ_W = 4;

  // signed q16.16 value
  typedef logic signed [31:0] q16_t;
  // q16.16 coefficient with one guard bit, so that a negated value cannot overflow
  typedef logic signed [32:0] coef_t;
  typedef logic [REQ_W-1:0] req_t;

  localparam req_t REQ_IDENTITY  = 4'd0;
  localparam req_t REQ_TRANSLATE = 4'd1;
  localparam req_t REQ_ROTATE    = 4'd2;
  localparam req_t REQ_SCALE     = 4'd3;
  localparam req_t REQ_REFLECT_X = 4'd4;
  localparam req_t REQ_REFLECT_Y = 4'd5;
  localparam req_t REQ_SHEAR_X   = 4'd6;
  localparam req_t REQ_SHEAR_Y   = 4'd7;
  localparam req_t REQ_POINT     = 4'd8;

  localparam q16_t  Q_ONE        = 32'sh0001_0000;
  localparam coef_t COEF_ONE     = 33'sh0_0001_0000;
  localparam coef_t COEF_NEG_ONE = 33'sh1_FFFF_0000;

endpackage

// ===== sv/aff_if.sv =====
// valid/ready channel interfaces for commands and transformed points
interface aff_cmd_if;
  import aff_pkg::*;

  logic valid;
  logic ready;
  req_t req_type;
  q16_t param_a;
  q16_t param_b;

  modport source (output valid, output req_type, output param_a, output param_b,
                  input ready);
  modport sink (input valid, input req_type, input param_a, input param_b,
                output ready);
endinterface

interface aff_res_if;
  import aff_pkg::*;

  logic valid;
  logic ready;
  q16_t out_x;
  q16_t out_y;

  modport source (output valid, output out_x, output out_y, input ready);
  modport sink (input valid, input out_x, input out_y, output ready);
endinterface

// ===== sv/aff_dot3.sv =====
// one output element: two rounded q16.16 products plus an offset, saturated to 32 bits
module aff_dot3 (
  input  aff_pkg::coef_t coef_a,
  input  aff_pkg::coef_t coef_b,
  input  aff_pkg::q16_t  val_a,
  input  aff_pkg::q16_t  val_b,
  input  aff_pkg::q16_t  offset,
  output aff_pkg::q16_t  result
);
  import aff_pkg::*;

  localparam logic signed [64:0] ROUND_HALF = 65'sd32768;
  localparam logic signed [50:0] SAT_MAX    = 51'sd2147483647;
  localparam logic signed [50:0] SAT_MIN    = -51'sd2147483648;

  logic signed [64:0] prod_a;
  logic signed [64:0] prod_b;
  logic signed [64:0] biased_a;
  logic signed [64:0] biased_b;
  logic signed [48:0] rnd_a;
  logic signed [48:0] rnd_b;
  logic signed [50:0] total;

  assign prod_a   = 65'(coef_a) * 65'(val_a);
  assign prod_b   = 65'(coef_b) * 65'(val_b);
  // round to nearest, ties up: add half an lsb, then floor
  assign biased_a = prod_a + ROUND_HALF;
  assign biased_b = prod_b + ROUND_HALF;
  assign rnd_a    = biased_a[64:16];
  assign rnd_b    = biased_b[64:16];
  assign total    = 51'(rnd_a) + 51'(rnd_b) + 51'(offset);

  always_comb begin
    if (total > SAT_MAX) begin
      result = Q_ONE - Q_ONE + 32'sh7FFF_FFFF;
    end else if (total < SAT_MIN) begin
      result = 32'sh8000_0000;
    end else begin
      result = total[31:0];
    end
  end

endmodule

// ===== sv/affine_transform_2d_engine.sv =====
// top level: affine matrix register, command decode, matrix update and point transform
// Holds the top two rows of a 2d homogeneous affine matrix in q16.16 (bottom row fixed at
// 0 0 1), reset to identity. Commands on cmd premultiply the matrix by an elementary
// transform (translate, rotate with cosine in param_a and sine in param_b, scale, reflect
// about x or y, shear x or y) or restore identity; they return nothing. A point command
// returns the matrix applied to (param_a, param_b, 1) on res. Every product is rounded to
// nearest with ties up, and every matrix element and output is saturated to 32 bits.
// Undefined command codes are dropped. Throughput is one transaction per cycle: a command
// sits in one input register, the six element updates and the point transform are each two
// 33x32 multiplies plus an add, done combinationally, so the matrix is updated in time for
// the very next command. A point passes from the input register into an output register and
// shows on res from there; cmd only stalls while a point waits behind a result that res has
// not yet taken.
module affine_transform_2d_engine (
  input logic      clk,
  input logic      rst,
  aff_cmd_if.sink  cmd,
  aff_res_if.source res
);
  import aff_pkg::*;

  // input register
  logic s1_valid;
  req_t s1_req;
  q16_t s1_a;
  q16_t s1_b;

  // held matrix m0..m5, row major
  q16_t matrix [6];
  q16_t matrix_next [6];

  // output register
  logic res_valid;
  q16_t out_x;
  q16_t out_y;
  q16_t pt_x;
  q16_t pt_y;

  logic is_point;
  logic out_free;
  logic s1_fire;
  logic mat_wr;

  // elementary transform rows [p q r; s t u]
  coef_t e_p;
  coef_t e_q;
  coef_t e_s;
  coef_t e_t;
  q16_t  e_r;
  q16_t  e_u;

  assign is_point  = (s1_req == REQ_POINT);
  assign out_free  = !res_valid || res.ready;
  // matrix commands never wait; a point waits for room in the output register
  assign s1_fire   = s1_valid && (!is_point || out_free);
  assign cmd.ready = !s1_valid || s1_fire;

  assign res.valid = res_valid;
  assign res.out_x = out_x;
  assign res.out_y = out_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      s1_req <= cmd.req_type;
      s1_a   <= cmd.param_a;
      s1_b   <= cmd.param_b;
    end
  end

  // decode the command into the top two rows of its elementary transform
  always_comb begin
    e_p    = COEF_ONE;
    e_q    = '0;
    e_r    = '0;
    e_s    = '0;
    e_t    = COEF_ONE;
    e_u    = '0;
    mat_wr = 1'b1;
    unique case (s1_req)
      REQ_TRANSLATE: begin
        e_r = s1_a;
        e_u = s1_b;
      end
      REQ_ROTATE: begin
        // sine negated at 33 bits so the most negative value stays exact
        e_p = 33'(s1_a);
        e_q = -33'(s1_b);
        e_s = 33'(s1_b);
        e_t = 33'(s1_a);
      end
      REQ_SCALE: begin
        e_p = 33'(s1_a);
        e_t = 33'(s1_b);
      end
      REQ_REFLECT_X: begin
        e_t = COEF_NEG_ONE;
      end
      REQ_REFLECT_Y: begin
        e_p = COEF_NEG_ONE;
      end
      REQ_SHEAR_X: begin
        e_q = 33'(s1_a);
      end
      REQ_SHEAR_Y: begin
        e_s = 33'(s1_a);
      end
      default: begin
        // identity, point and undefined codes leave the product path unused
        mat_wr = 1'b0;
      end
    endcase
  end

  // new matrix: one unit per element, each column of the held matrix against a row of e
  for (genvar j = 0; j < 3; j++) begin : g_col
    aff_dot3 u_top (
      .coef_a (e_p),
      .coef_b (e_q),
      .val_a  (matrix[j]),
      .val_b  (matrix[3+j]),
      .offset ((j == 2) ? e_r : q16_t'(0)),
      .result (matrix_next[j])
    );
    aff_dot3 u_bot (
      .coef_a (e_s),
      .coef_b (e_t),
      .val_a  (matrix[j]),
      .val_b  (matrix[3+j]),
      .offset ((j == 2) ? e_u : q16_t'(0)),
      .result (matrix_next[3+j])
    );
  end

  // point transform on the held matrix
  aff_dot3 u_pt_x (
    .coef_a (33'(matrix[0])),
    .coef_b (33'(matrix[1])),
    .val_a  (s1_a),
    .val_b  (s1_b),
    .offset (matrix[2]),
    .result (pt_x)
  );

  aff_dot3 u_pt_y (
    .coef_a (33'(matrix[3])),
    .coef_b (33'(matrix[4])),
    .val_a  (s1_a),
    .val_b  (s1_b),
    .offset (matrix[5]),
    .result (pt_y)
  );

  // matrix register: identity on reset and on the identity command
  always_ff @(posedge clk) begin
    if (rst || (s1_fire && s1_req == REQ_IDENTITY)) begin
      matrix[0] <= Q_ONE;
      matrix[1] <= '0;
      matrix[2] <= '0;
      matrix[3] <= '0;
      matrix[4] <= Q_ONE;
      matrix[5] <= '0;
    end else if (s1_fire && mat_wr) begin
      matrix <= matrix_next;
    end
  end

  // output register, freed as soon as res takes the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire && is_point) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && is_point) begin
      out_x <= pt_x;
      out_y <= pt_y;
    end
  end

endmodule

// ===== sv/aff_checker.sv =====
// port-level assertions for the affine transform engine, bound to the top level
module aff_checker (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_ready,
  input aff_pkg::req_t  cmd_req_type,
  input logic           res_valid,
  input logic           res_ready,
  input aff_pkg::q16_t  res_out_x,
  input aff_pkg::q16_t  res_out_y
);
  import aff_pkg::*;

  // points taken on cmd whose results have not yet been taken on res
  logic [1:0] pending;
  logic [1:0] pending_next;
  logic       pt_acc;
  logic       res_acc;

  assign pt_acc       = cmd_valid && cmd_ready && (cmd_req_type == REQ_POINT);
  assign res_acc      = res_valid && res_ready;
  assign pending_next = pending + 2'(pt_acc) - 2'(res_acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending_next;
    end
  end

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_out_x) && $stable(res_out_y))
    else $error("result changed before it was taken");

  a_res_has_point: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> pending != 2'd0)
    else $error("result shown with no point outstanding");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more points in flight than the pipeline holds");

  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !res_valid || res_ready |-> cmd_ready)
    else $error("cmd stalled while the output register is free");

endmodule

bind affine_transform_2d_engine aff_checker u_aff_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .cmd_req_type (cmd.req_type),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_out_x    (res.out_x),
  .res_out_y    (res.out_y)
);
